[rtl/vfd_pkg.sv]
// shared types and constants for the varint field decoder
package vfd_pkg;

  // value kind, taken from the action field on the first byte of a value
  typedef enum logic [1:0] {
    KIND_U32 = 2'd0,
    KIND_U64 = 2'd1,
    KIND_S32 = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OVERFLOW      = 2'd1,
    ST_PREMATURE_END = 2'd2
  } status_t;

  // decode state carried between bytes
  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  pos;
    kind_t       kind;
    logic        neg;
    logic        busy;
  } dec_state_t;

  // one result item
  typedef struct packed {
    logic [63:0] uval;
    logic [31:0] sval;
    status_t     status;
  } result_t;

  // byte fields and limits
  localparam int unsigned CONT_BIT      = 7;
  localparam logic [7:0]  U32_LAST_MASK = 8'hf0;
  localparam logic [7:0]  U64_LAST_MASK = 8'hfe;
  localparam logic [3:0]  U32_LAST_POS  = 4'd4;
  localparam logic [3:0]  U64_LAST_POS  = 4'd9;

endpackage

[rtl/vfd_step.sv]
// per-byte decode step: state and byte in, next state and result out
module vfd_step (
  input  vfd_pkg::dec_state_t state,
  input  logic [1:0]          action,
  input  logic [7:0]          data,
  input  logic                stream_end,
  output vfd_pkg::dec_state_t state_nxt,
  output logic                emit,
  output vfd_pkg::result_t    result
);

  vfd_pkg::dec_state_t cur;
  logic [6:0]  pos_x7;
  logic [5:0]  shamt;
  logic [63:0] data7;
  logic [63:0] acc_new;
  logic        neg_new;
  logic        last;
  logic        ovf;
  logic        done;
  logic [31:0] mag;

  // start a new value when idle
  always_comb begin
    cur = state;
    if (!state.busy) begin
      cur.acc  = '0;
      cur.pos  = '0;
      cur.neg  = 1'b0;
      cur.busy = 1'b1;
      if (action == vfd_pkg::KIND_U64) begin
        cur.kind = vfd_pkg::KIND_U64;
      end else if (action == vfd_pkg::KIND_S32) begin
        cur.kind = vfd_pkg::KIND_S32;
      end else begin
        cur.kind = vfd_pkg::KIND_U32;
      end
    end
  end

  // shift amount is seven times the byte position
  assign pos_x7 = {cur.pos, 3'b000} - {3'b000, cur.pos};
  assign shamt  = pos_x7[5:0];
  assign data7  = {57'd0, data[6:0]};

  // merge this byte into the accumulator
  always_comb begin
    acc_new = cur.acc;
    neg_new = cur.neg;
    last    = 1'b0;
    ovf     = 1'b0;
    unique case (cur.kind)
      vfd_pkg::KIND_U64: begin
        last = (cur.pos >= vfd_pkg::U64_LAST_POS);
        ovf  = last && ((data & vfd_pkg::U64_LAST_MASK) != 8'd0);
        if (last) begin
          acc_new = cur.acc | {data[0], 63'd0};
        end else begin
          acc_new = cur.acc | (data7 << shamt);
        end
      end
      vfd_pkg::KIND_S32: begin
        last = (cur.pos >= vfd_pkg::U32_LAST_POS);
        ovf  = last && ((data & vfd_pkg::U32_LAST_MASK) != 8'd0);
        if (last) begin
          acc_new = cur.acc | ({60'd0, data[3:0]} << 27);
        end else if (cur.pos == 4'd0) begin
          neg_new = data[0];
          acc_new = {58'd0, data[6:1]};
        end else begin
          acc_new = cur.acc | (data7 << (shamt - 6'd1));
        end
      end
      default: begin
        last = (cur.pos >= vfd_pkg::U32_LAST_POS);
        ovf  = last && ((data & vfd_pkg::U32_LAST_MASK) != 8'd0);
        if (last) begin
          acc_new = cur.acc | ({60'd0, data[3:0]} << 28);
        end else begin
          acc_new = cur.acc | (data7 << shamt);
        end
      end
    endcase
  end

  assign done = last || !data[vfd_pkg::CONT_BIT];
  assign mag  = {1'b0, acc_new[30:0]};

  // result and next state
  always_comb begin
    state_nxt     = '0;
    emit          = 1'b0;
    result.uval   = '0;
    result.sval   = '0;
    result.status = vfd_pkg::ST_OK;
    if (stream_end) begin
      emit          = 1'b1;
      result.status = vfd_pkg::ST_PREMATURE_END;
    end else if (ovf) begin
      emit          = 1'b1;
      result.status = vfd_pkg::ST_OVERFLOW;
    end else if (done) begin
      emit = 1'b1;
      unique case (cur.kind)
        vfd_pkg::KIND_U64: result.uval = acc_new;
        vfd_pkg::KIND_S32: result.sval = neg_new ? (32'd0 - mag) : mag;
        default:           result.uval = {32'd0, acc_new[31:0]};
      endcase
    end else begin
      state_nxt.acc  = acc_new;
      state_nxt.pos  = cur.pos + 4'd1;
      state_nxt.kind = cur.kind;
      state_nxt.neg  = neg_new;
      state_nxt.busy = 1'b1;
    end
  end

endmodule

[rtl/varint_field_decoder_core.sv]
// varint field decoder top level: decode state, output register and skid stage
// a result is registered in the output register, or in the skid entry while the output is stalled
// throughput: one byte per cycle while in_stall is low; each byte is one shift-and-or in the step logic
// a two-entry output (register plus skid) keeps input flowing for one stalled result
// in_stall rises only while both output entries are full
// synchronous active-low reset clears decode state and both output entries
module varint_field_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_byte,
  input  logic               in_stream_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_unsigned_value,
  output logic signed [31:0] out_signed_value,
  output logic [1:0]         out_status
);

  vfd_pkg::dec_state_t state_r;
  vfd_pkg::dec_state_t state_nxt;
  vfd_pkg::result_t    res;
  vfd_pkg::result_t    out_r;
  vfd_pkg::result_t    skid_r;
  logic                emit;
  logic                in_xfer;
  logic                res_valid;
  logic                out_free;
  logic                out_valid_r;
  logic                skid_valid_r;

  // per-byte decode logic
  vfd_step u_step (
    .state      (state_r),
    .action     (in_action),
    .data       (in_byte),
    .stream_end (in_stream_end),
    .state_nxt  (state_nxt),
    .emit       (emit),
    .result     (res)
  );

  assign in_xfer   = in_valid && !skid_valid_r;
  assign res_valid = in_xfer && emit;
  assign out_free  = !out_valid_r || !out_stall;

  // decode state and output valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r  <= skid_valid_r || res_valid;
        skid_valid_r <= 1'b0;
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign in_stall           = skid_valid_r;
  assign out_valid          = out_valid_r;
  assign out_unsigned_value = out_r.uval;
  assign out_signed_value   = out_r.sval;
  assign out_status         = out_r.status;

endmodule

[rtl/vfd_checker.sv]
// port-level checks for the varint field decoder, bound to the top level
module vfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_action,
  input logic [7:0]         in_byte,
  input logic               in_stream_end,
  input logic               out_valid,
  input logic               out_stall,
  input logic [63:0]        out_unsigned_value,
  input logic signed [31:0] out_signed_value,
  input logic [1:0]         out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_unsigned_value)
      && $stable(out_signed_value) && $stable(out_status))
    else $error("stalled result changed");

  // error results carry zero values
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != vfd_pkg::ST_OK) |->
      out_unsigned_value == 64'd0 && out_signed_value == 32'sd0)
    else $error("error result with nonzero value");

  // only one value field is ever nonzero and signed stays in range
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_signed_value == 32'sd0 || out_unsigned_value == 64'd0)
      && out_signed_value != 32'sh80000000)
    else $error("bad value fields");

  // end-of-input transfer is always followed by out_valid in the next cycle
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_stream_end |=> out_valid)
    else $error("no result after end of input");

  // input stalls only after the output was stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without output stall");

endmodule

bind varint_field_decoder_core vfd_checker u_vfd_checker (.*);

[test/tb.sv]
// testbench for the varint field decoder: byte stimulus, decode prediction, result check
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_TAIL  = 60;

  // one byte transfer as queued for the driver
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data;
    logic       stream_end;
    logic       wait_drain;
  } byte_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = '0;
  logic [7:0]         in_byte = '0;
  logic               in_stream_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [63:0]        out_unsigned_value;
  logic signed [31:0] out_signed_value;
  logic [1:0]         out_status;

  byte_item_t       pending_bytes[$];
  vfd_pkg::result_t predicted_values[$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               send_gap = 0;
  int               stall_left = 0;

  // decoder state as the predictor sees it
  logic [63:0]    acc_q = '0;
  logic [3:0]     pos_q = '0;
  vfd_pkg::kind_t kind_q = vfd_pkg::KIND_U32;
  logic           neg_q = 1'b0;
  logic           busy_q = 1'b0;

  varint_field_decoder_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_byte           (in_byte),
    .in_stream_end     (in_stream_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_unsigned_value(out_unsigned_value),
    .out_signed_value  (out_signed_value),
    .out_status        (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic vfd_pkg::kind_t kind_of(input logic [1:0] act);
    if (act == vfd_pkg::KIND_U64) return vfd_pkg::KIND_U64;
    if (act == vfd_pkg::KIND_S32) return vfd_pkg::KIND_S32;
    return vfd_pkg::KIND_U32;
  endfunction

  // advance the decode state by one byte, queue the value it finishes
  task automatic decode_byte(input logic [1:0] act, input logic [7:0] b, input logic se);
    vfd_pkg::result_t r;
    logic             done;
    logic [31:0]      mag;
    r = '0;
    r.status = vfd_pkg::ST_OK;
    done = 1'b0;
    if (se) begin
      r.status = vfd_pkg::ST_PREMATURE_END;
      done = 1'b1;
    end else begin
      if (!busy_q) begin
        kind_q = kind_of(act);
        acc_q = '0;
        pos_q = '0;
        neg_q = 1'b0;
        busy_q = 1'b1;
      end
      if (kind_q == vfd_pkg::KIND_U64 && pos_q >= vfd_pkg::U64_LAST_POS) begin
        // tenth byte carries only bit 63
        done = 1'b1;
        if (|(b & vfd_pkg::U64_LAST_MASK)) begin
          r.status = vfd_pkg::ST_OVERFLOW;
        end else begin
          acc_q[63] = acc_q[63] | b[0];
          r.uval = acc_q;
        end
      end else if (kind_q != vfd_pkg::KIND_U64 && pos_q >= vfd_pkg::U32_LAST_POS) begin
        // fifth byte carries only four bits
        done = 1'b1;
        if (|(b & vfd_pkg::U32_LAST_MASK)) begin
          r.status = vfd_pkg::ST_OVERFLOW;
        end else if (kind_q == vfd_pkg::KIND_S32) begin
          acc_q = acc_q | (64'(b[3:0]) << 27);
          mag = acc_q[31:0] & 32'h7fff_ffff;
          r.sval = neg_q ? -mag : mag;
        end else begin
          acc_q = acc_q | (64'(b[3:0]) << 28);
          r.uval = {32'h0, acc_q[31:0]};
        end
      end else begin
        if (kind_q == vfd_pkg::KIND_S32) begin
          if (pos_q == 4'd0) begin
            neg_q = b[0];
            acc_q = 64'(b[6:1]);
          end else begin
            acc_q = acc_q | (64'(b[6:0]) << (7 * int'(pos_q) - 1));
          end
        end else begin
          acc_q = acc_q | (64'(b[6:0]) << (7 * int'(pos_q)));
        end
        if (!b[vfd_pkg::CONT_BIT]) begin
          done = 1'b1;
          if (kind_q == vfd_pkg::KIND_S32) begin
            mag = acc_q[31:0] & 32'h7fff_ffff;
            r.sval = neg_q ? -mag : mag;
          end else if (kind_q == vfd_pkg::KIND_U32) begin
            r.uval = {32'h0, acc_q[31:0]};
          end else begin
            r.uval = acc_q;
          end
        end else begin
          pos_q = pos_q + 4'd1;
        end
      end
    end
    if (done) begin
      predicted_values.push_back(r);
      acc_q = '0;
      pos_q = '0;
      kind_q = vfd_pkg::KIND_U32;
      neg_q = 1'b0;
      busy_q = 1'b0;
    end
  endtask

  task automatic push_byte(input logic [1:0] act, input logic [7:0] b, input logic se,
                           input logic drain = 1'b0);
    byte_item_t it;
    it.action = act;
    it.data = b;
    it.stream_end = se;
    it.wait_drain = drain;
    pending_bytes.push_back(it);
  endtask

  // encode one value; pad chooses a random length from the minimal one up to the maximum
  task automatic push_value(input logic [1:0] act, input logic [63:0] v, input logic neg,
                            input logic pad);
    logic [71:0] bits;
    int          need;
    int          maxn;
    int          n;
    int          i;
    maxn = (kind_of(act) == vfd_pkg::KIND_U64) ? 10 : 5;
    if (kind_of(act) == vfd_pkg::KIND_S32) bits = {40'h0, v[30:0], neg};
    else if (kind_of(act) == vfd_pkg::KIND_U32) bits = {40'h0, v[31:0]};
    else bits = {8'h0, v};
    need = 1;
    for (i = 1; i < maxn; i++)
      if ((bits >> (7 * i)) != 0) need = i + 1;
    n = pad ? $urandom_range(maxn, need) : need;
    for (i = 0; i < n; i++)
      push_byte((i == 0) ? act : 2'($urandom_range(3, 0)),
                {(i < n - 1) ? 1'b1 : 1'b0, bits[7 * i +: 7]}, 1'b0);
  endtask

  // stimulus
  initial begin
    int          i;
    int          k;
    int          maxn;
    int          choice;
    logic [1:0]  act;
    logic [63:0] v;
    logic [7:0]  b;

    // directed: end of input while idle, unused kind, extremes, negative zero, overflow
    push_byte(2'd1, 8'h5a, 1'b1);
    push_value(2'd3, 64'h0, 1'b0, 1'b0);
    push_value(2'd0, 64'hffff_ffff, 1'b0, 1'b0);
    push_value(2'd1, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
    push_value(2'd2, 64'h0, 1'b1, 1'b0);
    push_value(2'd2, 64'h7fff_ffff, 1'b1, 1'b0);
    for (i = 0; i < 4; i++) push_byte((i == 0) ? 2'd0 : 2'd2, 8'hff, 1'b0);
    push_byte(2'd1, 8'h80, 1'b0);

    // random: mostly well-formed values, some overflow, truncation and noise
    k = 0;
    while (pending_bytes.size() < 600) begin
      if (k == 0 || k == 120) push_byte(2'd0, 8'h00, 1'b1, 1'b1);
      k++;
      choice = $urandom_range(99, 0);
      act = 2'($urandom_range(3, 0));
      maxn = (kind_of(act) == vfd_pkg::KIND_U64) ? 10 : 5;
      if (choice < 65) begin
        v = {$urandom, $urandom} >> $urandom_range(63, 0);
        if ($urandom_range(7, 0) == 0) v = '1;
        push_value(act, v, 1'($urandom_range(1, 0)), ($urandom_range(3, 0) == 0));
      end else if (choice < 78) begin
        for (i = 0; i < maxn - 1; i++)
          push_byte((i == 0) ? act : 2'($urandom_range(3, 0)),
                    8'($urandom_range(255, 0)) | 8'h80, 1'b0);
        b = 8'($urandom_range(255, 0));
        if (kind_of(act) == vfd_pkg::KIND_U64) b = b | (8'h02 << $urandom_range(6, 0));
        else b = b | (8'h10 << $urandom_range(3, 0));
        push_byte(2'($urandom_range(3, 0)), b, 1'b0);
      end else if (choice < 90) begin
        for (i = 0; i < $urandom_range(maxn - 1, 0); i++)
          push_byte((i == 0) ? act : 2'($urandom_range(3, 0)),
                    8'($urandom_range(255, 0)) | 8'h80, 1'b0);
        push_byte(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)), 1'b1);
      end else begin
        push_byte(act, 8'($urandom_range(255, 0)), ($urandom_range(7, 0) == 0));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then allow the output pipeline to settle
    while (pending_bytes.size() != 0 || in_valid || predicted_values.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // driver: hold a stalled transfer, insert idle bursts, predict on acceptance
  always @(posedge clk) begin
    logic       sent;
    logic       next_valid;
    byte_item_t it;
    sent = rst_n && in_valid && !in_stall;
    next_valid = in_valid && !sent;
    if (sent) decode_byte(in_action, in_byte, in_stream_end);
    if (rst_n && (!in_valid || sent)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_bytes.size() != 0) begin
        if (pending_bytes.size() > QUIET_TAIL && $urandom_range(5, 0) == 0) begin
          send_gap <= $urandom_range(16, 0);
        end else if (!pending_bytes[0].wait_drain || predicted_values.size() == 0) begin
          it = pending_bytes.pop_front();
          in_action <= it.action;
          in_byte <= it.data;
          in_stream_end <= it.stream_end;
          next_valid = 1'b1;
        end
      end
    end
    in_valid <= next_valid;
  end

  // result side: stall bursts and field comparison
  always @(posedge clk) begin
    vfd_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_values.size() == 0) begin
        $display("%0t: unexpected result uval=%h sval=%0d status=%0d", $time,
                 out_unsigned_value, out_signed_value, out_status);
        mismatch_count++;
      end else begin
        want = predicted_values.pop_front();
        if (out_unsigned_value !== want.uval) begin
          $display("%0t: unsigned_value expected %h actual %h", $time, want.uval,
                   out_unsigned_value);
          mismatch_count++;
        end
        if (out_signed_value !== want.sval) begin
          $display("%0t: signed_value expected %0d actual %0d", $time,
                   $signed(want.sval), out_signed_value);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatch_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (rst_n && pending_bytes.size() > QUIET_TAIL && $urandom_range(5, 0) == 0) begin
      stall_left <= $urandom_range(16, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

[filelist.f]
rtl/vfd_pkg.sv
rtl/vfd_step.sv
rtl/varint_field_decoder_core.sv
rtl/vfd_checker.sv
test/tb.sv
